@@ hdl/awvn_pkg.sv @@
// Shared types and constants for the angle-weighted vertex normal block.
// No dependencies.
`timescale 1ns / 1ps

package awvn_pkg;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned EDGE_W = POS_W + 1;

  localparam int unsigned CORDIC_STEPS = 17;
  localparam int unsigned CORDIC_IW    = 5;
  localparam logic [17:0] ANG_PI       = 18'd205887;
  localparam logic [17:0] ANG_HALF_PI  = 18'd102944;

  localparam logic signed [33:0] SUM_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SUM_MIN = -34'sd2147483647;

  typedef struct packed {
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic signed [POS_W-1:0] center_z;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] first_z;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic signed [POS_W-1:0] second_z;
    logic                    last_pair;
  } in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
  } out_t;

  // arctan(2^-i) in Q0.16 radians
  function automatic logic [15:0] atan_lut(input logic [CORDIC_IW-1:0] i);
    logic [15:0] r;
    unique case (i)
      5'd0:    r = 16'd51472;
      5'd1:    r = 16'd30386;
      5'd2:    r = 16'd16055;
      5'd3:    r = 16'd8150;
      5'd4:    r = 16'd4091;
      5'd5:    r = 16'd2047;
      5'd6:    r = 16'd1024;
      5'd7:    r = 16'd512;
      5'd8:    r = 16'd256;
      5'd9:    r = 16'd128;
      5'd10:   r = 16'd64;
      5'd11:   r = 16'd32;
      5'd12:   r = 16'd16;
      5'd13:   r = 16'd8;
      5'd14:   r = 16'd4;
      5'd15:   r = 16'd2;
      5'd16:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/awvn_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// No package dependencies.
`timescale 1ns / 1ps

module awvn_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] v_q, v_d;
  logic [63:0] r_q, r_d;
  logic [63:0] b_q, b_d;
  logic [63:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    v_d    = v_q;
    r_d    = r_q;
    b_d    = b_q;
    trial  = r_q + b_q;
    if (start_i) begin
      busy_d = 1'b1;
      v_d    = radicand_i;
      r_d    = '0;
      b_d    = 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d = v_q - trial;
        r_d = (r_q >> 1) + b_q;
      end else begin
        r_d = r_q >> 1;
      end
      b_d = b_q >> 2;
      if (b_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

@@ hdl/awvn_div.sv @@
// Restoring divider, one quotient bit per cycle; 31 or 17 quotient bits.
// Dividend must be below divisor * 2^bits. No package dependencies.
`timescale 1ns / 1ps

module awvn_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        long_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [30:0] quot_o
);

  localparam logic [4:0] LONG_BITS  = 5'd31;
  localparam logic [4:0] SHORT_BITS = 5'd17;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] rem_q, rem_d;
  logic [63:0] low_q, low_d;
  logic [31:0] dvs_q, dvs_d;
  logic [30:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] trial;
  logic        ge;
  logic [32:0] diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    low_d  = low_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    trial  = {rem_q, low_q[63]};
    ge     = trial >= {1'b0, dvs_q};
    diff   = trial - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      dvs_d  = divisor_i;
      quo_d  = '0;
      if (long_i) begin
        rem_d = 32'(dividend_i >> LONG_BITS);
        low_d = dividend_i << (7'd64 - {2'b0, LONG_BITS});
        cnt_d = LONG_BITS;
      end else begin
        rem_d = 32'(dividend_i >> SHORT_BITS);
        low_d = dividend_i << (7'd64 - {2'b0, SHORT_BITS});
        cnt_d = SHORT_BITS;
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[31:0] : trial[31:0];
      quo_d = {quo_q[29:0], ge};
      low_d = low_q << 1;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ hdl/awvn_cordic.sv @@
// Vectoring CORDIC for atan2(len, dot), one micro-rotation per cycle.
// Depends on awvn_pkg (arctangent table, angle limits).
`timescale 1ns / 1ps

module awvn_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] dot_i,
  input  logic [31:0]        len_i,
  output logic               done_o,
  output logic [17:0]        angle_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic signed [35:0]                  x_q, x_d;
  logic signed [35:0]                  y_q, y_d;
  logic signed [19:0]                  z_q, z_d;
  logic [awvn_pkg::CORDIC_IW-1:0]      i_q, i_d;
  logic signed [35:0]                  xs, ys;
  logic signed [19:0]                  at;
  logic signed [35:0]                  dot_x, len_x;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    i_d    = i_q;
    xs     = x_q >>> i_q;
    ys     = y_q >>> i_q;
    at     = $signed({4'b0, awvn_pkg::atan_lut(i_q)});
    dot_x  = 36'(dot_i);
    len_x  = $signed({4'b0, len_i});
    if (start_i) begin
      busy_d = 1'b1;
      i_d    = '0;
      if (dot_i < 0) begin
        x_d = len_x;
        y_d = -dot_x;
        z_d = $signed({2'b0, awvn_pkg::ANG_HALF_PI});
      end else begin
        x_d = dot_x;
        y_d = len_x;
        z_d = '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end
      i_d = i_q + 1'b1;
      if (i_q == awvn_pkg::CORDIC_IW'(awvn_pkg::CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  always_comb begin
    if (z_q < 0) begin
      angle_o = '0;
    end else if (z_q > $signed({2'b0, awvn_pkg::ANG_PI})) begin
      angle_o = awvn_pkg::ANG_PI;
    end else begin
      angle_o = z_q[17:0];
    end
  end

  assign done_o = done_q;

endmodule

@@ hdl/angle_weighted_vertex_normal.sv @@
// Angle-weighted vertex normal: sequencer, shared multiplier and accumulators.
// Depends on awvn_pkg, awvn_isqrt, awvn_div, awvn_cordic.
//
// Usage: one input transfer carries a vertex, one pair of its neighbours and a
// last_pair mark. Each pair adds its angle-weighted unit face normal to three
// running sums; the transfer marked last_pair also yields one output transfer
// with the normalized sum (Q1.15) and the degenerate flag, then clears the sums.
// Both channels are valid/ready. in_ready_o is high only while the sequencer
// is idle, so a new pair is taken only once the last one is through. A pair
// is shorter when an edge is zero or the cross product vanishes, and a last pair
// runs longer to normalize and emit. The time is set by the shared 32x32
// multiplier, the one-bit-per-cycle square root, the 17-step CORDIC and the
// restoring divider (31 or 17 quotient bits, once per component).
// The result sits in an output register: if the receiver stalls, the next
// pairs are still taken and only the next emission waits for the register.
// Reset (asynchronous, active low) clears the sums and drops any pending result.
`timescale 1ns / 1ps

module angle_weighted_vertex_normal (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  awvn_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output awvn_pkg::out_t  out_data_o
);

  localparam int unsigned EW = awvn_pkg::EDGE_W;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_EDGE   = 11'b000_0000_0010,
    S_MUL    = 11'b000_0000_0100,
    S_ACC    = 11'b000_0000_1000,
    S_SCALE  = 11'b000_0001_0000,
    S_SQRT   = 11'b000_0010_0000,
    S_CORDIC = 11'b000_0100_0000,
    S_DSET   = 11'b000_1000_0000,
    S_DIV    = 11'b001_0000_0000,
    S_FIN    = 11'b010_0000_0000,
    S_EMIT   = 11'b100_0000_0000
  } state_e;

  typedef enum logic [3:0] {
    OP_A1B2, OP_A2B1, OP_A2B0, OP_A0B2, OP_A0B1, OP_A1B0,
    OP_A0B0, OP_A1B1, OP_A2B2,
    OP_C0C0, OP_C1C1, OP_C2C2,
    OP_UANG,
    OP_S0S0, OP_S1S1, OP_S2S2
  } mul_op_e;

  state_e                 state_q, state_d;
  mul_op_e                op_q, op_d;
  logic [1:0]             k_q, k_d;
  logic                   last_q, last_d;
  logic                   fin_q, fin_d;
  logic signed [EW-1:0]   a_q [3];
  logic signed [EW-1:0]   a_d [3];
  logic signed [EW-1:0]   b_q [3];
  logic signed [EW-1:0]   b_d [3];
  logic signed [47:0]     c_q [3];
  logic signed [47:0]     c_d [3];
  logic signed [47:0]     d_q, d_d;
  logic signed [47:0]     acc_q, acc_d;
  logic signed [63:0]     p_q, p_d;
  logic [63:0]            q_q, q_d;
  logic [31:0]            len_q, len_d;
  logic [17:0]            ang_q, ang_d;
  logic signed [31:0]     u_q, u_d;
  logic signed [31:0]     sum_q [3];
  logic signed [31:0]     sum_d [3];
  logic signed [15:0]     n_q [3];
  logic signed [15:0]     n_d [3];
  logic                   degen_q, degen_d;
  logic [63:0]            dvd_q, dvd_d;
  logic                   sq_start_q, sq_start_d;
  logic                   co_start_q, co_start_d;
  logic                   dv_start_q, dv_start_d;
  logic                   out_valid_q, out_valid_d;
  awvn_pkg::out_t         out_q, out_d;

  logic signed [31:0]     mul_a, mul_b;
  logic                   sq_done, co_done, dv_done;
  logic [31:0]            sq_root;
  logic [17:0]            co_angle;
  logic [30:0]            dv_quot;

  logic                   edge_big, dot_big, a_zero, b_zero, c_zero;
  logic signed [63:0]     p_sh;
  logic signed [33:0]     sat_in;
  logic [47:0]            c_mag;
  logic [31:0]            s_mag;
  logic [16:0]            n_mag;

  function automatic logic signed [31:0] ext_e(input logic signed [EW-1:0] v);
    return 32'(v);
  endfunction

  function automatic logic big_e(input logic signed [EW-1:0] v);
    return (v >= $signed(EW'(1 << 22))) || (v <= -$signed(EW'(1 << 22)));
  endfunction

  function automatic logic big_c(input logic signed [47:0] v);
    return (v >= 48'sd1073741824) || (v <= -48'sd1073741824);
  endfunction

  // halve toward zero
  function automatic logic signed [EW-1:0] half_e(input logic signed [EW-1:0] v);
    return (v + $signed({{(EW-1){1'b0}}, v[EW-1]})) >>> 1;
  endfunction

  function automatic logic signed [47:0] half_c(input logic signed [47:0] v);
    return (v + $signed({47'b0, v[47]})) >>> 1;
  endfunction

  awvn_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start_q),
    .radicand_i (q_q),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  awvn_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (co_start_q),
    .dot_i   (d_q[31:0]),
    .len_i   (len_q),
    .done_o  (co_done),
    .angle_o (co_angle)
  );

  awvn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start_q),
    .long_i     (!fin_q),
    .dividend_i (dvd_q),
    .divisor_i  (len_q),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  always_comb begin
    unique case (op_q)
      OP_A1B2: begin mul_a = ext_e(a_q[1]); mul_b = ext_e(b_q[2]); end
      OP_A2B1: begin mul_a = ext_e(a_q[2]); mul_b = ext_e(b_q[1]); end
      OP_A2B0: begin mul_a = ext_e(a_q[2]); mul_b = ext_e(b_q[0]); end
      OP_A0B2: begin mul_a = ext_e(a_q[0]); mul_b = ext_e(b_q[2]); end
      OP_A0B1: begin mul_a = ext_e(a_q[0]); mul_b = ext_e(b_q[1]); end
      OP_A1B0: begin mul_a = ext_e(a_q[1]); mul_b = ext_e(b_q[0]); end
      OP_A0B0: begin mul_a = ext_e(a_q[0]); mul_b = ext_e(b_q[0]); end
      OP_A1B1: begin mul_a = ext_e(a_q[1]); mul_b = ext_e(b_q[1]); end
      OP_A2B2: begin mul_a = ext_e(a_q[2]); mul_b = ext_e(b_q[2]); end
      OP_C0C0: begin mul_a = c_q[0][31:0]; mul_b = c_q[0][31:0]; end
      OP_C1C1: begin mul_a = c_q[1][31:0]; mul_b = c_q[1][31:0]; end
      OP_C2C2: begin mul_a = c_q[2][31:0]; mul_b = c_q[2][31:0]; end
      OP_UANG: begin mul_a = u_q; mul_b = $signed({14'b0, ang_q}); end
      OP_S0S0: begin mul_a = sum_q[0]; mul_b = sum_q[0]; end
      OP_S1S1: begin mul_a = sum_q[1]; mul_b = sum_q[1]; end
      OP_S2S2: begin mul_a = sum_q[2]; mul_b = sum_q[2]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    k_d         = k_q;
    last_d      = last_q;
    fin_d       = fin_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    acc_d       = acc_q;
    p_d         = p_q;
    q_d         = q_q;
    len_d       = len_q;
    ang_d       = ang_q;
    u_d         = u_q;
    sum_d       = sum_q;
    n_d         = n_q;
    degen_d     = degen_q;
    dvd_d       = dvd_q;
    sq_start_d  = 1'b0;
    co_start_d  = 1'b0;
    dv_start_d  = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    edge_big = 1'b0;
    dot_big  = big_c(d_q);
    for (int i = 0; i < 3; i++) begin
      edge_big = edge_big | big_e(a_q[i]) | big_e(b_q[i]);
      dot_big  = dot_big | big_c(c_q[i]);
    end
    a_zero = (a_q[0] | a_q[1] | a_q[2]) == '0;
    b_zero = (b_q[0] | b_q[1] | b_q[2]) == '0;
    c_zero = (c_q[0] | c_q[1] | c_q[2]) == '0;

    p_sh   = p_q >>> 30;
    sat_in = 34'(sum_q[k_q]) + p_sh[33:0];
    c_mag  = c_q[k_q][47] ? 48'(-c_q[k_q]) : 48'(c_q[k_q]);
    s_mag  = sum_q[k_q][31] ? 32'(-sum_q[k_q]) : 32'(sum_q[k_q]);
    n_mag  = dv_quot[16:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          a_d[0] = EW'(in_data_i.first_x)  - EW'(in_data_i.center_x);
          a_d[1] = EW'(in_data_i.first_y)  - EW'(in_data_i.center_y);
          a_d[2] = EW'(in_data_i.first_z)  - EW'(in_data_i.center_z);
          b_d[0] = EW'(in_data_i.second_x) - EW'(in_data_i.center_x);
          b_d[1] = EW'(in_data_i.second_y) - EW'(in_data_i.center_y);
          b_d[2] = EW'(in_data_i.second_z) - EW'(in_data_i.center_z);
          last_d  = in_data_i.last_pair;
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        if (a_zero || b_zero) begin
          state_d = S_FIN;
        end else if (edge_big) begin
          for (int i = 0; i < 3; i++) begin
            a_d[i] = half_e(a_q[i]);
            b_d[i] = half_e(b_q[i]);
          end
        end else begin
          op_d    = OP_A1B2;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        p_d     = mul_a * mul_b;
        state_d = S_ACC;
      end
      S_ACC: begin
        op_d    = mul_op_e'(op_q + 4'd1);
        state_d = S_MUL;
        unique case (op_q)
          OP_A1B2, OP_A2B0, OP_A0B1, OP_A0B0: acc_d = p_q[47:0];
          OP_A2B1: c_d[0] = acc_q - p_q[47:0];
          OP_A0B2: c_d[1] = acc_q - p_q[47:0];
          OP_A1B0: c_d[2] = acc_q - p_q[47:0];
          OP_A1B1: acc_d  = acc_q + p_q[47:0];
          OP_A2B2: begin
            d_d     = acc_q + p_q[47:0];
            state_d = S_SCALE;
          end
          OP_C0C0, OP_S0S0: q_d = p_q;
          OP_C1C1, OP_S1S1: q_d = q_q + p_q;
          OP_C2C2, OP_S2S2: begin
            q_d        = q_q + p_q;
            sq_start_d = 1'b1;
            state_d    = S_SQRT;
          end
          OP_UANG: begin
            if (sat_in > awvn_pkg::SUM_MAX) begin
              sum_d[k_q] = awvn_pkg::SUM_MAX[31:0];
            end else if (sat_in < awvn_pkg::SUM_MIN) begin
              sum_d[k_q] = awvn_pkg::SUM_MIN[31:0];
            end else begin
              sum_d[k_q] = sat_in[31:0];
            end
            if (k_q == 2'd2) begin
              state_d = S_FIN;
            end else begin
              k_d     = k_q + 2'd1;
              state_d = S_DSET;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCALE: begin
        if (dot_big) begin
          d_d = half_c(d_q);
          for (int i = 0; i < 3; i++) c_d[i] = half_c(c_q[i]);
        end else if (c_zero) begin
          state_d = S_FIN;
        end else begin
          op_d    = OP_C0C0;
          state_d = S_MUL;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          len_d = sq_root;
          k_d   = 2'd0;
          if (fin_q) begin
            state_d = S_DSET;
          end else begin
            co_start_d = 1'b1;
            state_d    = S_CORDIC;
          end
        end
      end
      S_CORDIC: begin
        if (co_done) begin
          ang_d   = co_angle;
          state_d = S_DSET;
        end
      end
      S_DSET: begin
        if (fin_q) begin
          dvd_d = {17'b0, s_mag, 15'b0} + {33'b0, len_q[31:1]};
        end else begin
          dvd_d = {c_mag[33:0], 30'b0};
        end
        dv_start_d = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        if (dv_done) begin
          if (!fin_q) begin
            u_d     = c_q[k_q][47] ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});
            op_d    = OP_UANG;
            state_d = S_MUL;
          end else begin
            if (sum_q[k_q][31]) begin
              n_d[k_q] = -$signed(n_mag[15:0]);
            end else if (n_mag[16:15] != 2'b00) begin
              n_d[k_q] = 16'sh7fff;
            end else begin
              n_d[k_q] = $signed(n_mag[15:0]);
            end
            if (k_q == 2'd2) begin
              state_d = S_EMIT;
            end else begin
              k_d     = k_q + 2'd1;
              state_d = S_DSET;
            end
          end
        end
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0) begin
          for (int i = 0; i < 3; i++) n_d[i] = '0;
          degen_d = 1'b1;
          state_d = S_EMIT;
        end else begin
          degen_d = 1'b0;
          fin_d   = 1'b1;
          op_d    = OP_S0S0;
          state_d = S_MUL;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.normal_x   = n_q[0];
          out_d.normal_y   = n_q[1];
          out_d.normal_z   = n_q[2];
          out_d.degenerate = degen_q;
          out_valid_d      = 1'b1;
          for (int i = 0; i < 3; i++) sum_d[i] = '0;
          fin_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_A1B2;
      k_q         <= '0;
      last_q      <= 1'b0;
      fin_q       <= 1'b0;
      sq_start_q  <= 1'b0;
      co_start_q  <= 1'b0;
      dv_start_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      k_q         <= k_d;
      last_q      <= last_d;
      fin_q       <= fin_d;
      sq_start_q  <= sq_start_d;
      co_start_q  <= co_start_d;
      dv_start_q  <= dv_start_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    c_q     <= c_d;
    d_q     <= d_d;
    acc_q   <= acc_d;
    p_q     <= p_d;
    q_q     <= q_d;
    len_q   <= len_d;
    ang_q   <= ang_d;
    u_q     <= u_d;
    n_q     <= n_d;
    degen_q <= degen_d;
    dvd_q   <= dvd_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
